[src/brss_pkg.sv]
// ----------------------------------------------------------------------------
// Byte-range sector splitter package
// Field widths, codes and the result record shared by the splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package brss_pkg;

	localparam int SECTOR_BYTES = 512;
	localparam int SECTOR_SHIFT = 9;
	localparam int MAX_BATCH    = 255;

	localparam int LBA_W  = 28;
	localparam int BYTE_W = 38;
	localparam int POS_W  = 37;
	localparam int OFF_W  = 9;
	localparam int COPY_W = 10;
	localparam int CNT_W  = 8;
	localparam int OP_W   = 2;
	localparam int ST_W   = 3;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 136;

	localparam logic [LBA_W:0] LBA_LIMIT = 29'h0fff_ffff;

	localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

	localparam logic [ST_W-1:0] ST_ISSUED  = 3'd0;
	localparam logic [ST_W-1:0] ST_DONE    = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY   = 3'd2;
	localparam logic [ST_W-1:0] ST_FAILED  = 3'd3;
	localparam logic [ST_W-1:0] ST_IGNORED = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic              via_bounce;
		logic [LBA_W-1:0]  lba;
		logic [CNT_W-1:0]  sector_total;
		logic [POS_W-1:0]  user_offset;
		logic [OFF_W-1:0]  bounce_offset;
		logic [COPY_W-1:0] copy_bytes;
		logic              finished;
		logic [ST_W-1:0]   status;
		logic [POS_W-1:0]  transferred;
	} res_t;

	function automatic logic [CNT_W-1:0] batch_count(input logic [POS_W-1:0] left);
		logic [POS_W-SECTOR_SHIFT-1:0] whole;
		whole = left[POS_W-1:SECTOR_SHIFT];
		if (whole > (POS_W-SECTOR_SHIFT)'(MAX_BATCH))
			return CNT_W'(MAX_BATCH);
		return whole[CNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

[src/byte_range_sector_splitter.sv]
// ----------------------------------------------------------------------------
// Byte-range sector splitter
// Splits byte-range disk requests into sector commands with bounce merges.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transfer: tuser is the kind (new request or
//   completion), tdata the request fields and the completion flag. m_axis
//   returns exactly one result item per input item: tdata holds the command,
//   tlast marks the result that ends the request, tuser the status code.
//   disk_sectors is loaded through cfg_wr_en / cfg_wr_data; the user must do so while idle (not enforced).
// Timing:
//   An accepted item is held in an input register; its result is loaded into
//   the output register once that register is free. The state
//   update and result come from one pass of logic, so one item per cycle is
//   sustained while m_axis_tready stays high.
// Reset and stall:
//   arst_n clears the request state to idle, disk_sectors to zero and both
//   registers to empty. While m_axis_tready is low, the result holds and one
//   more item may wait in the input register; then s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_range_sector_splitter import brss_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [LBA_W-1:0]      cfg_wr_data,   // disk_sectors
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // is_write, byte_offset, byte_length, cmd_ok
	input  wire logic                  s_axis_tuser,  // kind
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // op, via_bounce, lba, sector_total,
	                                                  // user_offset, bounce_offset, copy_bytes,
	                                                  // transferred
	output logic [ST_W-1:0]            m_axis_tuser,  // status
	output logic                       m_axis_tlast   // finished
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEAD_READ,
		PH_HEAD_WRITE,
		PH_BATCH,
		PH_TAIL_READ,
		PH_TAIL_WRITE
	} phase_t;

	logic [LBA_W-1:0]  disk_sectors_q;
	phase_t            phase_q, phase_d;
	logic              wmode_q, wmode_d;
	logic [LBA_W-1:0]  nsec_q, nsec_d;
	logic [POS_W-1:0]  left_q, left_d;
	logic [POS_W-1:0]  upos_q, upos_d;
	logic [POS_W-1:0]  rbytes_q, rbytes_d;
	logic [OFF_W-1:0]  moff_q, moff_d;
	logic [COPY_W-1:0] mlen_q, mlen_d;

	logic              valid_s1;
	logic              kind_s1;
	logic              wr_s1;
	logic [BYTE_W-1:0] off_s1;
	logic [BYTE_W-1:0] len_s1;
	logic              ok_s1;

	logic              out_valid_q;
	res_t              out_q;
	res_t              res;

	logic              out_free;
	logic              advance;

	logic [POS_W-1:0]  disk_bytes;
	logic [POS_W-1:0]  room;
	logic [POS_W-1:0]  clamp;
	logic [COPY_W-1:0] avail;
	logic [CNT_W-1:0]  cur_batch;
	logic [POS_W-1:0]  cur_batch_bytes;

	logic              body_go;
	logic              body_wm;
	logic [POS_W-1:0]  body_left;
	logic [LBA_W-1:0]  body_nsec;
	logic [POS_W-1:0]  body_upos;
	logic [POS_W-1:0]  body_rbytes;
	logic [CNT_W-1:0]  body_batch;
	logic [LBA_W:0]    body_last;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	assign disk_bytes = {disk_sectors_q, {SECTOR_SHIFT{1'b0}}};
	assign room       = disk_bytes - off_s1[POS_W-1:0];
	assign clamp      = (len_s1 > {1'b0, room}) ? room : len_s1[POS_W-1:0];
	assign avail      = COPY_W'(SECTOR_BYTES) - {1'b0, off_s1[OFF_W-1:0]};

	assign cur_batch       = batch_count(left_q);
	assign cur_batch_bytes = {(POS_W-SECTOR_SHIFT-CNT_W)'(0), cur_batch, {SECTOR_SHIFT{1'b0}}};

	assign body_batch = batch_count(body_left);
	assign body_last  = {1'b0, body_nsec} + (LBA_W+1)'(body_batch) - (LBA_W+1)'(1);

	always_comb begin
		phase_d     = phase_q;
		wmode_d     = wmode_q;
		nsec_d      = nsec_q;
		left_d      = left_q;
		upos_d      = upos_q;
		rbytes_d    = rbytes_q;
		moff_d      = moff_q;
		mlen_d      = mlen_q;
		res         = '0;
		body_go     = 1'b0;
		body_wm     = wmode_q;
		body_left   = left_q;
		body_nsec   = nsec_q;
		body_upos   = upos_q;
		body_rbytes = rbytes_q;

		if (!kind_s1) begin
			if (phase_q != PH_IDLE) begin
				res.status = ST_IGNORED;
			end else if (off_s1 >= {1'b0, disk_bytes} || clamp == '0) begin
				phase_d      = PH_IDLE;
				left_d       = '0;
				res.finished = 1'b1;
				res.status   = ST_EMPTY;
			end else begin
				wmode_d  = wr_s1;
				rbytes_d = clamp;
				left_d   = clamp;
				upos_d   = '0;
				nsec_d   = off_s1[SECTOR_SHIFT +: LBA_W];
				if (off_s1[OFF_W-1:0] != '0) begin
					moff_d            = off_s1[OFF_W-1:0];
					mlen_d            = (clamp < POS_W'(avail)) ? clamp[COPY_W-1:0] : avail;
					phase_d           = PH_HEAD_READ;
					res.op            = OP_READ;
					res.via_bounce    = 1'b1;
					res.lba           = off_s1[SECTOR_SHIFT +: LBA_W];
					res.sector_total  = CNT_W'(1);
					res.bounce_offset = off_s1[OFF_W-1:0];
					res.copy_bytes    = wr_s1 ? '0 :
						((clamp < POS_W'(avail)) ? clamp[COPY_W-1:0] : avail);
					res.status        = ST_ISSUED;
				end else begin
					body_go     = 1'b1;
					body_wm     = wr_s1;
					body_left   = clamp;
					body_nsec   = off_s1[SECTOR_SHIFT +: LBA_W];
					body_upos   = '0;
					body_rbytes = clamp;
				end
			end
		end else if (phase_q == PH_IDLE) begin
			res.status = ST_IGNORED;
		end else if (!ok_s1) begin
			phase_d      = PH_IDLE;
			left_d       = '0;
			res.finished = 1'b1;
			res.status   = ST_FAILED;
		end else begin
			case (phase_q)
				PH_HEAD_READ, PH_HEAD_WRITE: begin
					if (phase_q == PH_HEAD_READ && wmode_q) begin
						phase_d           = PH_HEAD_WRITE;
						res.op            = OP_WRITE;
						res.via_bounce    = 1'b1;
						res.lba           = nsec_q;
						res.sector_total  = CNT_W'(1);
						res.user_offset   = upos_q;
						res.bounce_offset = moff_q;
						res.copy_bytes    = mlen_q;
						res.status        = ST_ISSUED;
					end else begin
						upos_d    = upos_q + POS_W'(mlen_q);
						left_d    = left_q - POS_W'(mlen_q);
						nsec_d    = nsec_q + LBA_W'(1);
						body_go   = 1'b1;
						body_left = left_q - POS_W'(mlen_q);
						body_nsec = nsec_q + LBA_W'(1);
						body_upos = upos_q + POS_W'(mlen_q);
					end
				end
				PH_BATCH: begin
					upos_d    = upos_q + cur_batch_bytes;
					left_d    = left_q - cur_batch_bytes;
					nsec_d    = nsec_q + LBA_W'(cur_batch);
					body_go   = 1'b1;
					body_left = left_q - cur_batch_bytes;
					body_nsec = nsec_q + LBA_W'(cur_batch);
					body_upos = upos_q + cur_batch_bytes;
				end
				PH_TAIL_READ: begin
					if (wmode_q) begin
						phase_d          = PH_TAIL_WRITE;
						res.op           = OP_WRITE;
						res.via_bounce   = 1'b1;
						res.lba          = nsec_q;
						res.sector_total = CNT_W'(1);
						res.user_offset  = upos_q;
						res.copy_bytes   = mlen_q;
						res.status       = ST_ISSUED;
					end else begin
						phase_d         = PH_IDLE;
						left_d          = '0;
						res.finished    = 1'b1;
						res.status      = ST_DONE;
						res.transferred = rbytes_q;
					end
				end
				default: begin
					phase_d         = PH_IDLE;
					left_d          = '0;
					res.finished    = 1'b1;
					res.status      = ST_DONE;
					res.transferred = rbytes_q;
				end
			endcase
		end

		if (body_go) begin
			if (body_left[POS_W-1:SECTOR_SHIFT] != '0) begin
				if (body_last > LBA_LIMIT) begin
					phase_d      = PH_IDLE;
					left_d       = '0;
					res.finished = 1'b1;
					res.status   = ST_FAILED;
				end else begin
					phase_d          = PH_BATCH;
					res.op           = body_wm ? OP_WRITE : OP_READ;
					res.lba          = body_nsec;
					res.sector_total = body_batch;
					res.user_offset  = body_upos;
					res.status       = ST_ISSUED;
				end
			end else if (body_left != '0) begin
				moff_d           = '0;
				mlen_d           = body_left[COPY_W-1:0];
				phase_d          = PH_TAIL_READ;
				res.op           = OP_READ;
				res.via_bounce   = 1'b1;
				res.lba          = body_nsec;
				res.sector_total = CNT_W'(1);
				res.user_offset  = body_upos;
				res.copy_bytes   = body_wm ? '0 : body_left[COPY_W-1:0];
				res.status       = ST_ISSUED;
			end else begin
				phase_d         = PH_IDLE;
				left_d          = '0;
				res.finished    = 1'b1;
				res.status      = ST_DONE;
				res.transferred = body_rbytes;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_sectors_q <= '0;
			phase_q        <= PH_IDLE;
			wmode_q        <= 1'b0;
			nsec_q         <= '0;
			left_q         <= '0;
			upos_q         <= '0;
			rbytes_q       <= '0;
			moff_q         <= '0;
			mlen_q         <= '0;
			valid_s1       <= 1'b0;
			kind_s1        <= 1'b0;
			wr_s1          <= 1'b0;
			off_s1         <= '0;
			len_s1         <= '0;
			ok_s1          <= 1'b0;
			out_valid_q    <= 1'b0;
			out_q          <= '0;
		end else begin
			if (cfg_wr_en) begin
				disk_sectors_q <= cfg_wr_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
				kind_s1  <= s_axis_tuser;
				wr_s1    <= s_axis_tdata[0];
				off_s1   <= s_axis_tdata[BYTE_W:1];
				len_s1   <= s_axis_tdata[2*BYTE_W:BYTE_W+1];
				ok_s1    <= s_axis_tdata[2*BYTE_W+1];
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				phase_q     <= phase_d;
				wmode_q     <= wmode_d;
				nsec_q      <= nsec_d;
				left_q      <= left_d;
				upos_q      <= upos_d;
				rbytes_q    <= rbytes_d;
				moff_q      <= moff_d;
				mlen_q      <= mlen_d;
				out_q       <= res;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_q.finished;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {
		(OUT_DATA_W-132)'(0),
		out_q.transferred,
		out_q.copy_bytes,
		out_q.bounce_offset,
		out_q.user_offset,
		out_q.sector_total,
		out_q.lba,
		out_q.via_bounce,
		out_q.op
	};

endmodule

`default_nettype wire
